// ----- rtl/demand_paging_mmu_clock_macros.svh -----
// Assertion macros of the paging MMU RTL.
`ifndef DEMAND_PAGING_MMU_CLOCK_MACROS_SVH
`define DEMAND_PAGING_MMU_CLOCK_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DPM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dpm assertion failed");

// Next-cycle implication, disabled while reset is low.
`define DPM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dpm assertion failed");

`endif

// ----- rtl/dpm_pkg.sv -----
// Shared types and constants of the paging MMU.
`timescale 1ns / 1ps
`default_nettype none
package dpm_pkg;

    localparam int DPM_FRAMES        = 64;
    localparam int DPM_SWAP_PAGES    = 64;
    localparam int DPM_SYSTEM_FRAMES = 8;
    localparam int DPM_TABLE_ENTRIES = 256;

    localparam int VA_W      = 16;
    localparam int PAGE_BITS = 10;
    localparam int FIELD_W   = 6;
    localparam int PTE_W     = 16;
    localparam int BASE_W    = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // entry flag positions
    localparam int BIT_DEF   = 15;
    localparam int BIT_DIRTY = 14;
    localparam int BIT_REF   = 13;
    localparam int BIT_PAGED = 12;

    // register index (paddr bit 2)
    localparam logic REG_IDX_TABLE_BASE = 1'b0;

    typedef enum logic [1:0] {
        KIND_XLATE = 2'd0,
        KIND_SWOUT = 2'd1,
        KIND_SWIN  = 2'd2,
        KIND_ZERO  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLR,
        WR_REFCLR,
        WR_VICTIM,
        WR_VZERO,
        WR_FIN
    } wr_sel_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_LOOK,
        S_CHK,
        S_FSCAN,
        S_HRD,
        S_HCHK,
        S_SSCAN,
        S_EMIT_OUT,
        S_EMIT_IN,
        S_FIN,
        S_EMIT_T
    } state_t;

    typedef struct packed {
        logic    clr_inc;
        logic    load;
        logic    rd_main;
        logic    rd_hand;
        logic    latch_entry;
        logic    miss_init;
        logic    fscan_inc;
        logic    fscan_take;
        logic    hand_adv;
        logic    victim;
        logic    sscan_inc;
        logic    swap_take;
        logic    swap_none;
        logic    emit;
        kind_t   emit_kind;
        logic    swap_rel;
        logic    fin;
        wr_sel_t wr_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic ent_def;
        logic ent_paged;
        logic fscan_skip;
        logic frame_free;
        logic fscan_last;
        logic rd_def;
        logic rd_ref;
        logic steps_last;
        logic swap_free;
        logic sscan_last;
        logic out_free;
    } dp_sts_t;

endpackage
`default_nettype wire

// ----- rtl/dpm_ctrl.sv -----
// Controller state machine of the paging MMU.
`timescale 1ns / 1ps
`default_nettype none
module dpm_ctrl
    import dpm_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) state_next = S_RD;
            end
            S_RD:   state_next = S_LOOK;
            S_LOOK: state_next = S_CHK;
            S_CHK: begin
                if (sts.ent_def)         state_next = S_FIN;
                else if (sts.fscan_skip) state_next = S_HRD;
                else                     state_next = S_FSCAN;
            end
            S_FSCAN: begin
                if (sts.frame_free)      state_next = S_EMIT_IN;
                else if (sts.fscan_last) state_next = S_HRD;
            end
            S_HRD: state_next = S_HCHK;
            S_HCHK: begin
                if (sts.rd_def && !sts.rd_ref) state_next = S_SSCAN;
                else if (sts.steps_last)       state_next = S_EMIT_IN;
                else                           state_next = S_HRD;
            end
            S_SSCAN: begin
                if (sts.swap_free)       state_next = S_EMIT_OUT;
                else if (sts.sscan_last) state_next = S_EMIT_IN;
            end
            S_EMIT_OUT: begin
                if (sts.out_free) state_next = S_EMIT_IN;
            end
            S_EMIT_IN: begin
                if (sts.out_free) state_next = S_FIN;
            end
            S_FIN: state_next = S_EMIT_T;
            S_EMIT_T: begin
                if (sts.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        cmd = '0;
        cmd.emit_kind = KIND_XLATE;
        cmd.wr_sel = WR_NONE;
        s_ready = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_inc = 1'b1;
                cmd.wr_sel  = WR_CLR;
            end
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_RD:   cmd.rd_main = 1'b1;
            S_LOOK: cmd.latch_entry = 1'b1;
            S_CHK: begin
                cmd.miss_init = !sts.ent_def;
            end
            S_FSCAN: begin
                if (sts.frame_free) cmd.fscan_take = 1'b1;
                else                cmd.fscan_inc  = !sts.fscan_last;
            end
            S_HRD: cmd.rd_hand = 1'b1;
            S_HCHK: begin
                if (sts.rd_def && !sts.rd_ref) begin
                    cmd.victim = 1'b1;
                end else begin
                    cmd.hand_adv = 1'b1;
                    if (sts.rd_def) cmd.wr_sel = WR_REFCLR;
                end
            end
            S_SSCAN: begin
                if (sts.swap_free) begin
                    cmd.swap_take = 1'b1;
                    cmd.wr_sel    = WR_VICTIM;
                end else if (sts.sscan_last) begin
                    cmd.swap_none = 1'b1;
                    cmd.wr_sel    = WR_VZERO;
                end else begin
                    cmd.sscan_inc = 1'b1;
                end
            end
            S_EMIT_OUT: begin
                cmd.emit      = sts.out_free;
                cmd.emit_kind = KIND_SWOUT;
            end
            S_EMIT_IN: begin
                cmd.emit      = sts.out_free;
                cmd.emit_kind = sts.ent_paged ? KIND_SWIN : KIND_ZERO;
                cmd.swap_rel  = sts.out_free && sts.ent_paged;
            end
            S_FIN: begin
                cmd.fin    = 1'b1;
                cmd.wr_sel = WR_FIN;
            end
            S_EMIT_T: begin
                cmd.emit      = sts.out_free;
                cmd.emit_kind = KIND_XLATE;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/dpm_dp.sv -----
// Datapath of the paging MMU: page-table memory, bitmaps, hand and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "demand_paging_mmu_clock_macros.svh"
module dpm_dp
    import dpm_pkg::*;
#(
    parameter int FRAMES        = DPM_FRAMES,
    parameter int SWAP_PAGES    = DPM_SWAP_PAGES,
    parameter int SYSTEM_FRAMES = DPM_SYSTEM_FRAMES,
    parameter int TABLE_ENTRIES = DPM_TABLE_ENTRIES
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dp_cmd_t           cmd,
    output dp_sts_t                sts,
    input  wire logic [BASE_W-1:0] table_base,
    input  wire logic [VA_W-1:0]   s_virt_addr,
    input  wire logic              s_is_write,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_kind,
    output logic [FIELD_W-1:0]     m_frame_num,
    output logic [FIELD_W-1:0]     m_swap_page,
    output logic [VA_W-1:0]        m_phys_addr,
    output logic                   m_swap_full,
    output logic                   m_last
);

    localparam int TW = $clog2(TABLE_ENTRIES);
    localparam int FW = $clog2(FRAMES);
    localparam int SW = (SWAP_PAGES > 1) ? $clog2(SWAP_PAGES) : 1;
    localparam int ST = $clog2(2 * TABLE_ENTRIES + 1);
    localparam int SUM_W = 11;
    localparam int MAX_SUM = (1 << (VA_W - PAGE_BITS)) - 1 + (1 << BASE_W) - 1;
    localparam int WRAP_STEPS = MAX_SUM / TABLE_ENTRIES + 1;

    // page-table memory
    logic [PTE_W-1:0] pt_mem [TABLE_ENTRIES];
    logic [PTE_W-1:0] rdata_reg;

    // bitmaps and counters
    logic [FRAMES-1:0]     frame_used_reg;
    logic [SWAP_PAGES-1:0] swap_used_reg;
    logic [TW-1:0]         clr_idx_reg;
    logic [TW-1:0]         hand_reg;
    logic [ST-1:0]         steps_reg;
    logic [FW-1:0]         fscan_reg;
    logic [SW-1:0]         sscan_reg;
    logic                  m_valid_reg;

    // per-access payload registers
    logic [TW-1:0]        addr_reg;
    logic [PAGE_BITS-1:0] offset_reg;
    logic                 is_write_reg;
    logic [PTE_W-1:0]     entry_reg;
    logic [PTE_W-1:0]     victim_reg;
    logic [FIELD_W-1:0]   frame_reg;
    logic [FIELD_W-1:0]   swout_reg;
    logic                 full_reg;
    logic [1:0]           m_kind_reg;
    logic [FIELD_W-1:0]   m_frame_reg;
    logic [FIELD_W-1:0]   m_swap_reg;
    logic [VA_W-1:0]      m_phys_reg;
    logic                 m_full_reg;
    logic                 m_last_reg;

    logic [SUM_W-1:0]   wrap_sum;
    logic [PTE_W-1:0]   fin_entry;
    logic [PTE_W-1:0]   wr_data;
    logic [TW-1:0]      wr_addr;
    logic [TW-1:0]      rd_addr;
    logic               wr_en;
    logic [FIELD_W-1:0] swin_page;
    logic               out_free;

    // table index: page plus base, wrapped into the region
    always_comb begin
        wrap_sum = SUM_W'(s_virt_addr[VA_W-1:PAGE_BITS]) + SUM_W'(table_base);
        for (int i = 0; i < WRAP_STEPS; i++) begin
            if (wrap_sum >= SUM_W'(TABLE_ENTRIES)) wrap_sum = wrap_sum - SUM_W'(TABLE_ENTRIES);
        end
    end

    // final entry of the accessed page
    always_comb begin
        if (entry_reg[BIT_DEF]) begin
            fin_entry = entry_reg;
            fin_entry[BIT_DIRTY] = entry_reg[BIT_DIRTY] | is_write_reg;
        end else begin
            fin_entry = {1'b1, 1'b1, entry_reg[BIT_REF], 1'b0, 6'b0, frame_reg};
        end
    end

    // memory write selection
    always_comb begin
        wr_en   = 1'b1;
        wr_addr = hand_reg;
        wr_data = '0;
        case (cmd.wr_sel)
            WR_CLR:    wr_addr = clr_idx_reg;
            WR_REFCLR: begin
                wr_data = rdata_reg;
                wr_data[BIT_REF] = 1'b0;
            end
            WR_VICTIM: wr_data = {1'b0, 1'b0, victim_reg[BIT_REF], 1'b1, 6'b0,
                                  FIELD_W'(sscan_reg)};
            WR_VZERO:  wr_data = '0;
            WR_FIN: begin
                wr_addr = addr_reg;
                wr_data = fin_entry;
            end
            default:   wr_en = 1'b0;
        endcase
    end

    assign rd_addr   = cmd.rd_hand ? hand_reg : addr_reg;
    assign swin_page = entry_reg[FIELD_W-1:0];
    assign out_free  = !m_valid_reg || m_ready;

    // page-table memory port
    always_ff @(posedge aclk) begin
        if (wr_en) pt_mem[wr_addr] <= wr_data;
        if (cmd.rd_main || cmd.rd_hand) rdata_reg <= pt_mem[rd_addr];
    end

    // control state: bitmaps, hand, counters, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_used_reg <= '0;
            swap_used_reg  <= '0;
            clr_idx_reg    <= '0;
            hand_reg       <= '0;
            steps_reg      <= '0;
            fscan_reg      <= '0;
            sscan_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.clr_inc) clr_idx_reg <= clr_idx_reg + 1'b1;
            if (cmd.miss_init) begin
                fscan_reg <= FW'(SYSTEM_FRAMES);
                steps_reg <= '0;
            end
            if (cmd.fscan_inc)  fscan_reg <= fscan_reg + 1'b1;
            if (cmd.fscan_take) frame_used_reg[fscan_reg] <= 1'b1;
            if (cmd.hand_adv) begin
                hand_reg  <= (hand_reg == TW'(TABLE_ENTRIES - 1)) ? '0 : hand_reg + 1'b1;
                steps_reg <= steps_reg + 1'b1;
            end
            if (cmd.victim)    sscan_reg <= '0;
            if (cmd.sscan_inc) sscan_reg <= sscan_reg + 1'b1;
            if (cmd.swap_take) swap_used_reg[sscan_reg] <= 1'b1;
            if (cmd.swap_rel && (32'(swin_page) < SWAP_PAGES)) begin
                swap_used_reg[swin_page[SW-1:0]] <= 1'b0;
            end
            if (cmd.emit)         m_valid_reg <= 1'b1;
            else if (m_ready)     m_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg     <= wrap_sum[TW-1:0];
            offset_reg   <= s_virt_addr[PAGE_BITS-1:0];
            is_write_reg <= s_is_write;
            full_reg     <= 1'b0;
        end
        if (cmd.latch_entry) entry_reg <= rdata_reg;
        if (cmd.miss_init)   frame_reg <= FIELD_W'(SYSTEM_FRAMES);
        if (cmd.fscan_take)  frame_reg <= FIELD_W'(fscan_reg);
        if (cmd.victim) begin
            victim_reg <= rdata_reg;
            frame_reg  <= rdata_reg[FIELD_W-1:0];
        end
        if (cmd.swap_take) swout_reg <= FIELD_W'(sscan_reg);
        if (cmd.swap_none) full_reg  <= 1'b1;
        if (cmd.fin)       frame_reg <= fin_entry[FIELD_W-1:0];
        // result register
        if (cmd.emit) begin
            m_kind_reg  <= cmd.emit_kind;
            m_frame_reg <= frame_reg;
            m_full_reg  <= full_reg;
            m_last_reg  <= (cmd.emit_kind == KIND_XLATE);
            m_phys_reg  <= (cmd.emit_kind == KIND_XLATE) ? {frame_reg, offset_reg} : '0;
            case (cmd.emit_kind)
                KIND_SWOUT: m_swap_reg <= swout_reg;
                KIND_SWIN:  m_swap_reg <= swin_page;
                default:    m_swap_reg <= '0;
            endcase
        end
    end

    // status to the controller
    always_comb begin
        sts.clr_last   = (clr_idx_reg == TW'(TABLE_ENTRIES - 1));
        sts.ent_def    = entry_reg[BIT_DEF];
        sts.ent_paged  = entry_reg[BIT_PAGED];
        sts.fscan_skip = (SYSTEM_FRAMES >= FRAMES);
        sts.frame_free = !frame_used_reg[fscan_reg];
        sts.fscan_last = (fscan_reg == FW'(FRAMES - 1));
        sts.rd_def     = rdata_reg[BIT_DEF];
        sts.rd_ref     = rdata_reg[BIT_REF];
        sts.steps_last = (steps_reg == ST'(2 * TABLE_ENTRIES));
        sts.swap_free  = !swap_used_reg[sscan_reg];
        sts.sscan_last = (sscan_reg == SW'(SWAP_PAGES - 1));
        sts.out_free   = out_free;
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_frame_num = m_frame_reg;
    assign m_swap_page = m_swap_reg;
    assign m_phys_addr = m_phys_reg;
    assign m_swap_full = m_full_reg;
    assign m_last      = m_last_reg;

    // checks
    `DPM_ASSERT_IMP(a_emit_free, aclk, aresetn, cmd.emit, out_free)
    `DPM_ASSERT_IMP(a_last_xlate, aclk, aresetn, m_valid_reg && m_last_reg,
                    m_kind_reg == KIND_XLATE)
    `DPM_ASSERT_IMP(a_take_free, aclk, aresetn, cmd.fscan_take, !frame_used_reg[fscan_reg])

endmodule
`default_nettype wire

// ----- rtl/demand_paging_mmu_clock.sv -----
// Top level of the demand-paging MMU with clock replacement.
//
//  Channel   Direction  Handshake          Carries
//  s_        in         s_valid/s_ready    virt_addr, is_write
//  m_        out        m_valid/m_ready    kind, frame_num, swap_page, phys_addr,
//                                          swap_full, last
//  APB       in         psel/penable       table_base at byte address 0
//
// After reset the page table is swept to zero with s_ready low.
// A hit passes through the read, look-up, check, finish and emit states before
// the translation result is valid; the next access is taken only back in idle.
// A miss with a free frame scans the frame bitmap, up to FRAMES - SYSTEM_FRAMES
// bits; an eviction steps the hand (memory read then check), up to
// 2*TABLE_ENTRIES+1 steps, then scans the swap bitmap.
// Each command ahead of the translation result has its own emit state; a full output
// register holds the controller in its emit state until m_ready.
// The last result may wait in the output register while the next access is taken.
`timescale 1ns / 1ps
`default_nettype none
module demand_paging_mmu_clock
    import dpm_pkg::*;
#(
    parameter int FRAMES        = DPM_FRAMES,
    parameter int SWAP_PAGES    = DPM_SWAP_PAGES,
    parameter int SYSTEM_FRAMES = DPM_SYSTEM_FRAMES,
    parameter int TABLE_ENTRIES = DPM_TABLE_ENTRIES
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [VA_W-1:0]       s_virt_addr,
    input  wire logic                  s_is_write,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_kind,
    output logic [FIELD_W-1:0]         m_frame_num,
    output logic [FIELD_W-1:0]         m_swap_page,
    output logic [VA_W-1:0]            m_phys_addr,
    output logic                       m_swap_full,
    output logic                       m_last
);

    logic [BASE_W-1:0] table_base_reg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_base_reg <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_IDX_TABLE_BASE)) begin
            table_base_reg <= pwdata[BASE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_TABLE_BASE) ? APB_DATA_W'(table_base_reg) : '0;

    dpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dpm_dp #(
        .FRAMES        (FRAMES),
        .SWAP_PAGES    (SWAP_PAGES),
        .SYSTEM_FRAMES (SYSTEM_FRAMES),
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .table_base  (table_base_reg),
        .s_virt_addr (s_virt_addr),
        .s_is_write  (s_is_write),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_frame_num (m_frame_num),
        .m_swap_page (m_swap_page),
        .m_phys_addr (m_phys_addr),
        .m_swap_full (m_swap_full),
        .m_last      (m_last)
    );

endmodule
`default_nettype wire

// ----- sim/tb_demand_paging_mmu_clock.sv -----
// Testbench for the demand-paging MMU: directed and random accesses checked against a local model.
`timescale 1ns / 1ps
module tb_demand_paging_mmu_clock;
    import dpm_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 40;
    localparam logic [15:0] PTE_DEF   = 16'h8000;
    localparam logic [15:0] PTE_DIRTY = 16'h4000;
    localparam logic [15:0] PTE_REF   = 16'h2000;
    localparam logic [15:0] PTE_PAGED = 16'h1000;
    localparam logic [15:0] PTE_FLAGS = 16'hF000;

    typedef struct {
        kind_t       kind;
        logic [5:0]  frame;
        logic [5:0]  swp;
        logic [15:0] phys;
        logic        full;
        logic        last;
    } mmu_cmd_t;

    logic aclk;
    logic aresetn;
    logic psel, penable, pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;
    logic s_valid, s_ready;
    logic [VA_W-1:0] s_virt_addr;
    logic s_is_write;
    logic m_valid, m_ready;
    logic [1:0] m_kind;
    logic [FIELD_W-1:0] m_frame_num, m_swap_page;
    logic [VA_W-1:0] m_phys_addr;
    logic m_swap_full, m_last;

    // shadow MMU state
    logic [15:0] shadow_pt [256];
    logic        shadow_frame_used [64];
    logic        shadow_swap_used [64];
    int unsigned shadow_hand;
    logic [7:0]  shadow_base;

    mmu_cmd_t expected_cmds[$];
    int  error_count;
    bit  hold_rx;
    int  idle_cycles;

    demand_paging_mmu_clock dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_virt_addr(s_virt_addr), .s_is_write(s_is_write),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_kind(m_kind), .m_frame_num(m_frame_num), .m_swap_page(m_swap_page),
        .m_phys_addr(m_phys_addr), .m_swap_full(m_swap_full), .m_last(m_last)
    );

    // clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic void push_cmd(kind_t k, logic [5:0] f, logic [5:0] s,
                                     logic [15:0] p, logic full, logic last);
        mmu_cmd_t c;
        c.kind = k;
        c.frame = f;
        c.swp = s;
        c.phys = p;
        c.full = full;
        c.last = last;
        expected_cmds.push_back(c);
    endfunction

    // Translate one access and queue the commands it should produce.
    function automatic void translate_access(logic [15:0] va, logic wr);
        logic [5:0]  page;
        logic [9:0]  offset;
        logic [7:0]  idx;
        logic [15:0] entry;
        logic [15:0] e;
        logic [5:0]  frame;
        logic [5:0]  sw_out;
        logic        full;
        logic        got;
        logic        do_out;
        logic        done;
        int          h;
        page = va[15:10];
        offset = va[9:0];
        idx = 8'(page) + shadow_base;
        entry = shadow_pt[idx];
        full = 1'b0;
        do_out = 1'b0;
        sw_out = '0;
        if (entry & PTE_DEF) begin
            if (wr) entry |= PTE_DIRTY;
        end else begin
            got = 1'b0;
            frame = 6'(DPM_SYSTEM_FRAMES);
            for (int f = DPM_SYSTEM_FRAMES; f < DPM_FRAMES && !got; f++) begin
                if (!shadow_frame_used[f]) begin
                    shadow_frame_used[f] = 1'b1;
                    frame = 6'(f);
                    got = 1'b1;
                end
            end
            // clock sweep for a victim
            if (!got) begin
                done = 1'b0;
                for (int steps = 0; steps < 2 * 256 + 1 && !done; steps++) begin
                    h = shadow_hand % 256;
                    e = shadow_pt[h];
                    shadow_hand = h;
                    if (e & PTE_DEF) begin
                        if (e & PTE_REF) begin
                            shadow_pt[h] = e & ~PTE_REF;
                        end else begin
                            frame = e[5:0];
                            for (int s = 0; s < DPM_SWAP_PAGES && !do_out; s++) begin
                                if (!shadow_swap_used[s]) begin
                                    shadow_swap_used[s] = 1'b1;
                                    sw_out = 6'(s);
                                    do_out = 1'b1;
                                end
                            end
                            if (do_out) begin
                                shadow_pt[h] = (((e & ~(PTE_DEF | PTE_DIRTY)) | PTE_PAGED)
                                                & PTE_FLAGS) | {10'b0, sw_out};
                            end else begin
                                full = 1'b1;
                                shadow_pt[h] = '0;
                            end
                            done = 1'b1;
                        end
                    end
                    if (!done) shadow_hand = (h + 1) % 256;
                end
            end
            if (do_out) push_cmd(KIND_SWOUT, frame, sw_out, '0, full, 1'b0);
            if (entry & PTE_PAGED) begin
                push_cmd(KIND_SWIN, frame, entry[5:0], '0, full, 1'b0);
                shadow_swap_used[entry[5:0]] = 1'b0;
                entry &= ~PTE_PAGED;
            end else begin
                push_cmd(KIND_ZERO, frame, '0, '0, full, 1'b0);
            end
            entry = ((entry | PTE_DEF | PTE_DIRTY) & PTE_FLAGS) | {10'b0, frame};
        end
        shadow_pt[idx] = entry;
        push_cmd(KIND_XLATE, entry[5:0], '0, {entry[5:0], offset}, full, 1'b1);
    endfunction

    // Send one access; the payload holds until the transfer.
    task automatic send_access(logic [15:0] va, logic wr);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_virt_addr <= va;
        s_is_write <= wr;
        do @(posedge aclk); while (!s_ready);
        translate_access(va, wr);
    endtask

    // Wait until every queued command has been seen, then let the block settle.
    task automatic drain;
        s_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write of table_base, done only while idle.
    task automatic set_table_base(logic [7:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({REG_IDX_TABLE_BASE, 2'b00});
        pwdata <= {24'b0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_base = value;
        @(posedge aclk);
    endtask

    // Fresh pages map to the lowest free frames, zeroed; offsets at both ends.
    task automatic test_first_touch;
        set_table_base(8'd0);
        send_access(16'h0000, 1'b0);
        send_access(16'hFFFF, 1'b1);
        send_access(16'h0400, 1'b1);
        send_access(16'h83FF, 1'b0);
    endtask

    // Hits, read and write, including the dirty update, then two fresh pages.
    task automatic test_hits;
        send_access(16'h0123, 1'b1);
        send_access(16'hFC00, 1'b0);
        send_access(16'h07FF, 1'b0);
        send_access(16'h5555, 1'b1);
        send_access(16'hAAAA, 1'b0);
    endtask

    // Table index wraps past the end of the region.
    task automatic test_index_wrap;
        set_table_base(8'd255);
        send_access(16'hFC01, 1'b1);
        send_access(16'h0402, 1'b0);
        set_table_base(8'd192);
        send_access(16'hFFFE, 1'b0);
        send_access(16'h0000, 1'b1);
        set_table_base(8'd193);
        send_access(16'hF800, 1'b1);
    endtask

    // Receiver holds off while accesses keep coming, so the input stalls.
    task automatic test_backpressure;
        set_table_base(8'd64);
        hold_rx = 1'b1;
        for (int i = 0; i < 20; i++) send_access(16'($urandom), 1'($urandom));
    endtask

    // Random phases over several bases; about half the accesses revisit recent pages
    // so hits, evictions, swap-ins and a full swap space all occur.
    task automatic test_random_traffic;
        logic [15:0] recent[$];
        logic [15:0] va;
        logic [7:0]  bases[6];
        bases = '{8'd0, 8'd128, 8'd192, 8'd32, 8'd64, 8'd200};
        foreach (bases[p]) begin
            set_table_base(p == 5 ? 8'($urandom) : bases[p]);
            for (int i = 0; i < 58; i++) begin
                if (recent.size() > 0 && $urandom_range(0, 1) == 0)
                    va = {recent[$urandom_range(0, recent.size() - 1)][15:10],
                          10'($urandom)};
                else
                    va = 16'($urandom);
                recent.push_back(va);
                if (recent.size() > 24) void'(recent.pop_front());
                send_access(va, 1'($urandom));
            end
        end
    endtask

    // Result receiver: random stalls per result, one long hold-off on request.
    initial begin
        int n;
        m_ready = 1'b0;
        forever begin
            if (hold_rx) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_rx = 1'b0;
            end
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Check each result transfer against the oldest expected command.
    always @(posedge aclk) begin
        mmu_cmd_t c;
        if (aresetn && m_valid && m_ready) begin
            if (expected_cmds.size() == 0) begin
                $error("unexpected result: kind %0d frame %0d", m_kind, m_frame_num);
                error_count++;
            end else begin
                c = expected_cmds.pop_front();
                if (m_kind !== c.kind) begin
                    $error("kind: expected %0d, actual %0d", c.kind, m_kind);
                    error_count++;
                end
                if (m_frame_num !== c.frame) begin
                    $error("frame_num: expected %0d, actual %0d", c.frame, m_frame_num);
                    error_count++;
                end
                if (m_swap_page !== c.swp) begin
                    $error("swap_page: expected %0d, actual %0d", c.swp, m_swap_page);
                    error_count++;
                end
                if (m_phys_addr !== c.phys) begin
                    $error("phys_addr: expected %h, actual %h", c.phys, m_phys_addr);
                    error_count++;
                end
                if (m_swap_full !== c.full) begin
                    $error("swap_full: expected %0d, actual %0d", c.full, m_swap_full);
                    error_count++;
                end
                if (m_last !== c.last) begin
                    $error("last: expected %0d, actual %0d", c.last, m_last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        error_count = 0;
        hold_rx = 1'b0;
        idle_cycles = 0;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_virt_addr = '0;
        s_is_write = 1'b0;
        foreach (shadow_pt[i]) shadow_pt[i] = '0;
        foreach (shadow_frame_used[i]) shadow_frame_used[i] = 1'b0;
        foreach (shadow_swap_used[i]) shadow_swap_used[i] = 1'b0;
        shadow_hand = 0;
        shadow_base = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_first_touch();
        test_hits();
        test_index_wrap();
        test_backpressure();
        test_random_traffic();
        drain();

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
